// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the ir remote motor controller
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/nirmc_pkg.sv -----
// package for the ir remote motor controller: phase codes, key codes,
// segment table and motor pin helpers; no dependencies
`default_nettype none

package nirmc_pkg;

	localparam int PHASE_W = 3;

	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LEADER   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_GAPHIGH  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WAITHIGH = 3'd4;
	localparam logic [PHASE_W-1:0] PH_MEASURE  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DEAD     = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_ONE      = 2'd1;
	localparam logic [1:0] REG_ABORT    = 2'd2;
	localparam logic [1:0] REG_DEAD     = 2'd3;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd15;
	localparam logic [7:0]  ONE_RST      = 8'd8;
	localparam logic [7:0]  ABORT_RST    = 8'd30;
	localparam logic [15:0] DEAD_RST     = 16'd1714;

	localparam int FRAME_BITS = 32;

	// remote command bytes
	localparam logic [7:0] KEY_FWD        = 8'h12;
	localparam logic [7:0] KEY_BACK       = 8'h18;
	localparam logic [7:0] KEY_LEFT       = 8'h14;
	localparam logic [7:0] KEY_RIGHT      = 8'h16;
	localparam logic [7:0] KEY_STOP_ALL   = 8'h10;
	localparam logic [7:0] KEY_STOP_DRIVE = 8'h17;
	localparam logic [7:0] KEY_STOP_STEER = 8'h19;

	// pending motor moves
	localparam logic [2:0] MV_NONE  = 3'd0;
	localparam logic [2:0] MV_FWD   = 3'd1;
	localparam logic [2:0] MV_BACK  = 3'd2;
	localparam logic [2:0] MV_LEFT  = 3'd3;
	localparam logic [2:0] MV_RIGHT = 3'd4;

	localparam logic [3:0] PINS_STEER = 4'h3;
	localparam logic [3:0] PINS_DRIVE = 4'hC;

	typedef logic [3:0] pins_t;

	// active-low segment pattern for a decimal digit
	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] s;
		begin
			case (d)
				4'd0: s = 8'h03;
				4'd1: s = 8'h9F;
				4'd2: s = 8'h25;
				4'd3: s = 8'h0D;
				4'd4: s = 8'h99;
				4'd5: s = 8'h49;
				4'd6: s = 8'h41;
				4'd7: s = 8'h1F;
				4'd8: s = 8'h01;
				4'd9: s = 8'h19;
				default: s = 8'h03;
			endcase
			return s;
		end
	endfunction

	function automatic logic [2:0] move_of_key(input logic [7:0] key);
		logic [2:0] mv;
		begin
			case (key)
				KEY_FWD:   mv = MV_FWD;
				KEY_BACK:  mv = MV_BACK;
				KEY_LEFT:  mv = MV_LEFT;
				KEY_RIGHT: mv = MV_RIGHT;
				default:   mv = MV_NONE;
			endcase
			return mv;
		end
	endfunction

	// stop the motor that a move will use
	function automatic pins_t stop_for_move(input pins_t p, input logic [2:0] mv);
		pins_t r;
		begin
			if (mv == MV_FWD || mv == MV_BACK) r = p & PINS_STEER;
			else r = p & PINS_DRIVE;
			return r;
		end
	endfunction

	function automatic pins_t drive_move(input pins_t p, input logic [2:0] mv);
		pins_t r;
		begin
			case (mv)
				MV_FWD:   r = (p & PINS_STEER) | 4'h8;
				MV_BACK:  r = (p & PINS_STEER) | 4'h4;
				MV_LEFT:  r = (p & PINS_DRIVE) | 4'h2;
				MV_RIGHT: r = (p & PINS_DRIVE) | 4'h1;
				default:  r = p;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nec_ir_remote_motor_command.sv -----
// each accepted sample beat loads the result register, which holds it until its result beat
// throughput: one sample beat per cycle; the input stalls only while the result register
//   is full and the output side stalls
// reset (arst_n low, asynchronous): decoder idle, motors stopped, display shows digit zero,
//   configuration back to debounce 15, one 8, abort 30, dead 1714 ticks
// depends on nirmc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nec_ir_remote_motor_command
	import nirmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        ir_level,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             m1_fwd,
	output logic             m1_rev,
	output logic             m2_fwd,
	output logic             m2_rev,
	output logic [7:0]       segments,
	output logic             key_valid,
	output logic [7:0]       key_code,
	output logic             busy_res
);

	// configuration registers
	logic [7:0]  debounce_q, one_q, abort_q;
	logic [15:0] dead_q;

	// decoder and motor state
	logic               last_level_q;
	logic [PHASE_W-1:0] phase_q;
	logic [15:0]        tick_q;
	logic [5:0]         bit_q;
	logic [31:0]        frame_q;
	pins_t              pins_q;
	logic [7:0]         disp_q;
	logic [2:0]         pend_q;
	logic [7:0]         key_q;

	// result register
	logic        out_valid_q;
	pins_t       out_pins_q;
	logic [7:0]  out_seg_q;
	logic        out_kv_q;
	logic [7:0]  out_key_q;
	logic        out_busy_q;

	// next state
	logic [PHASE_W-1:0] n_phase;
	logic [15:0]        n_tick;
	logic [5:0]         n_bit;
	logic [31:0]        n_frame;
	pins_t              n_pins;
	logic [7:0]         n_disp;
	logic [2:0]         n_pend;
	logic [7:0]         n_key;
	logic               n_valid;

	logic        in_beat;
	logic        out_beat;
	logic [15:0] tick_inc;
	logic [5:0]  bit_inc;
	logic [31:0] shifted;
	logic [7:0]  cmd;
	logic [2:0]  mv;
	pins_t       stopped;

	// a new sample may enter unless a finished result still waits downstream
	assign in_stall = out_valid_q & out_stall;
	assign in_beat  = in_valid & ~in_stall;
	assign out_beat = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			one_q      <= ONE_RST;
			abort_q    <= ABORT_RST;
			dead_q     <= DEAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				REG_ONE:      one_q      <= cfg_data[7:0];
				REG_ABORT:    abort_q    <= cfg_data[7:0];
				REG_DEAD:     dead_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tick_inc = tick_q + 16'd1;
	assign bit_inc  = bit_q + 6'd1;
	// bit shifts in at the top, so the first bit ends at the bottom after 32
	assign shifted  = {(tick_q >= {8'd0, one_q}), frame_q[31:1]};
	assign cmd      = shifted[23:16];
	assign mv       = move_of_key(cmd);
	assign stopped  = stop_for_move(pins_q, mv);

	always_comb begin
		n_phase = phase_q;
		n_tick  = tick_q;
		n_bit   = bit_q;
		n_frame = frame_q;
		n_pins  = pins_q;
		n_disp  = disp_q;
		n_pend  = pend_q;
		n_key   = key_q;
		n_valid = 1'b0;
		case (phase_q)
			PH_DEBOUNCE: begin
				// a zero debounce still waits one tick
				n_tick = tick_inc;
				if (tick_inc >= {8'd0, debounce_q}) begin
					n_tick  = 16'd0;
					n_phase = ir_level ? PH_IDLE : PH_LEADER;
				end
			end
			PH_LEADER: begin
				if (ir_level) n_phase = PH_GAPHIGH;
			end
			PH_GAPHIGH: begin
				if (!ir_level) n_phase = PH_WAITHIGH;
			end
			PH_WAITHIGH: begin
				// first high tick of a bit; abort limit of 0 or 1 drops at once
				if (ir_level) begin
					n_tick  = 16'd1;
					n_phase = (abort_q <= 8'd1) ? PH_IDLE : PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (ir_level) begin
					n_tick = tick_inc;
					if (tick_inc >= {8'd0, abort_q}) n_phase = PH_IDLE;
				end else begin
					n_frame = shifted;
					n_tick  = 16'd0;
					n_bit   = bit_inc;
					if (bit_inc >= 6'(FRAME_BITS)) begin
						n_bit = 6'd0;
						// command byte against its 8-bit complement
						if (cmd == ~shifted[31:24]) begin
							n_valid = 1'b1;
							n_key   = cmd;
							n_disp  = cmd;
							n_phase = PH_IDLE;
							case (cmd)
								KEY_STOP_ALL: begin
									n_pins = 4'h0;
									n_disp = seg_digit(4'd0);
								end
								KEY_STOP_DRIVE: begin
									n_pins = pins_q & PINS_STEER;
									n_disp = seg_digit(4'd6);
								end
								KEY_STOP_STEER: begin
									n_pins = pins_q & PINS_DRIVE;
									n_disp = seg_digit(4'd7);
								end
								default: ;
							endcase
							if (mv != MV_NONE) begin
								if (dead_q == 16'd0) begin
									// no dead time: drive right away
									n_pins = drive_move(stopped, mv);
									n_disp = seg_digit({1'b0, mv});
								end else begin
									n_pins  = stopped;
									n_pend  = mv;
									n_tick  = 16'd0;
									n_phase = PH_DEAD;
								end
							end
						end else begin
							n_phase = PH_IDLE;
						end
					end else begin
						n_phase = PH_WAITHIGH;
					end
				end
			end
			PH_DEAD: begin
				// motor held stopped, then driven with its digit shown
				n_tick = tick_inc;
				if (tick_inc >= dead_q) begin
					n_pins  = drive_move(pins_q, pend_q);
					n_disp  = seg_digit({1'b0, pend_q});
					n_pend  = MV_NONE;
					n_tick  = 16'd0;
					n_phase = PH_IDLE;
				end
			end
			default: begin
				// only a falling edge seen while idle opens a frame
				if (last_level_q && !ir_level) begin
					n_phase = PH_DEBOUNCE;
					n_tick  = 16'd0;
					n_bit   = 6'd0;
				end else begin
					n_phase = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			phase_q      <= PH_IDLE;
			tick_q       <= 16'd0;
			bit_q        <= 6'd0;
			frame_q      <= 32'd0;
			pins_q       <= 4'h0;
			disp_q       <= seg_digit(4'd0);
			pend_q       <= MV_NONE;
			key_q        <= 8'd0;
		end else if (in_beat) begin
			last_level_q <= ir_level;
			phase_q      <= n_phase;
			tick_q       <= n_tick;
			bit_q        <= n_bit;
			frame_q      <= n_frame;
			pins_q       <= n_pins;
			disp_q       <= n_disp;
			pend_q       <= n_pend;
			key_q        <= n_key;
		end
	end

	// result register: loads on every sample beat, empties on an output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_beat) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_pins_q <= n_pins;
			out_seg_q  <= n_disp;
			out_kv_q   <= n_valid;
			out_key_q  <= n_key;
			out_busy_q <= (n_phase != PH_IDLE);
		end
	end

	assign out_valid = out_valid_q;
	assign m1_fwd    = out_pins_q[0];
	assign m1_rev    = out_pins_q[1];
	assign m2_fwd    = out_pins_q[2];
	assign m2_rev    = out_pins_q[3];
	assign segments  = out_seg_q;
	assign key_valid = out_kv_q;
	assign key_code  = out_key_q;
	assign busy_res  = out_busy_q;

	// a dead-time wait always has a move to finish
	`ASSERT_IMPL(a_dead_has_move, clk, arst_n, phase_q == PH_DEAD, pend_q != MV_NONE)
	// a motor is never driven on both terminals
	`ASSERT_IMPL(a_pins_exclusive, clk, arst_n, 1'b1,
		!(pins_q[0] && pins_q[1]) && !(pins_q[2] && pins_q[3]))
	// every sample beat leaves a result waiting
	`ASSERT_NEXT(a_beat_gives_result, clk, arst_n, in_beat, out_valid_q)
	// bit counter stays inside one frame
	`ASSERT_IMPL(a_bit_range, clk, arst_n, 1'b1, bit_q < 6'(FRAME_BITS))

endmodule

`default_nettype wire
